[design/bsws_pkg.sv]
// shared types and constants for the bounded stack with search
// no dependencies; imported by the controller, datapath and top level
package bsws_pkg;

    // fixed field widths
    localparam int DATA_W = 32;
    localparam int POS_W  = 4;

    // operation codes carried on the mode field
    typedef enum logic [1:0] {
        MODE_PUSH = 2'd0,
        MODE_POP  = 2'd1,
        MODE_SHOW = 2'd2,
        MODE_FIND = 2'd3
    } t_mode;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_EMIT,
        S_CHECK,
        S_REPLY
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    take;       // latch the input beat
        logic    push_wr;    // write key at the fill position, bump fill
        logic    idx_top;    // point the read index at the top entry
        logic    idx_dec;    // step the read index one entry down
        logic    fill_dec;   // drop the top entry
        logic    out_load;   // load the output register
        logic    out_entry;  // output data comes from the read entry
        logic    out_last;   // last flag of the loaded beat
        t_status reply_st;   // status of the loaded beat
        logic    reply_hit;  // loaded beat carries a search position
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        t_mode mode;
        logic  empty;
        logic  full;
        logic  idx_zero;
        logic  match;
        logic  out_free;
    } t_stat;

endpackage

[design/bsws_ctrl.sv]
// controller state machine for the bounded stack with search
// depends on bsws_pkg; drives the datapath through a command struct
module bsws_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  bsws_pkg::t_stat i_stat,
    output bsws_pkg::t_cmd  o_cmd,
    output logic            o_stall
);
    import bsws_pkg::*;

    t_state  r_state, n_state;
    t_status r_reply, n_reply;
    logic    r_hit, n_hit;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // pending single-beat reply
    always_ff @(posedge i_clk) begin
        r_reply <= n_reply;
        r_hit   <= n_hit;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_reply = r_reply;
        n_hit   = r_hit;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_hit = 1'b0;
                if (i_stat.mode == MODE_PUSH) begin
                    n_reply = i_stat.full ? ST_FULL : ST_OK;
                    n_state = S_REPLY;
                end else if (i_stat.empty) begin
                    n_reply = ST_EMPTY;
                    n_state = S_REPLY;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = (i_stat.mode == MODE_FIND) ? S_CHECK : S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    if (i_stat.mode == MODE_POP || i_stat.idx_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_CHECK: begin
                if (i_stat.match) begin
                    n_reply = ST_OK;
                    n_hit   = 1'b1;
                    n_state = S_REPLY;
                end else if (i_stat.idx_zero) begin
                    n_reply = ST_NOTFOUND;
                    n_state = S_REPLY;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_REPLY: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.reply_st = ST_OK;
        o_stall        = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.take = 1'b1;
            end
            S_DECODE: begin
                if (i_stat.mode == MODE_PUSH) begin
                    o_cmd.push_wr = !i_stat.full;
                end else begin
                    o_cmd.idx_top = !i_stat.empty;
                end
            end
            S_FETCH: begin
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_entry = 1'b1;
                    if (i_stat.mode == MODE_POP) begin
                        o_cmd.out_last = 1'b1;
                        o_cmd.fill_dec = 1'b1;
                    end else begin
                        o_cmd.out_last = i_stat.idx_zero;
                        o_cmd.idx_dec  = !i_stat.idx_zero;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.idx_dec = !i_stat.match && !i_stat.idx_zero;
            end
            S_REPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_last  = 1'b1;
                    o_cmd.reply_st  = r_reply;
                    o_cmd.reply_hit = r_hit;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[design/bsws_dpath.sv]
// datapath of the bounded stack with search: entry memory, fill count,
// read index, key compare and output register; depends on bsws_pkg
module bsws_dpath #(
    parameter int DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic [1:0]                            i_mode,
    input  logic signed [bsws_pkg::DATA_W-1:0]    i_value,
    input  logic                                  i_stall,
    input  bsws_pkg::t_cmd                        i_cmd,
    output bsws_pkg::t_stat                       o_stat,
    output logic                                  o_valid,
    output logic [1:0]                            o_status,
    output logic signed [bsws_pkg::DATA_W-1:0]    o_data,
    output logic [bsws_pkg::POS_W-1:0]            o_position,
    output logic                                  o_last
);
    import bsws_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_key;
    t_mode             r_mode;
    logic [CW-1:0]     r_fill;
    logic [AW-1:0]     r_idx;
    logic              r_out_valid;
    t_status           r_status;
    logic [DATA_W-1:0] r_data;
    logic [POS_W-1:0]  r_pos;
    logic              r_last;
    logic              out_free;
    logic [31:0]       pos_full;

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_valid) begin
            r_mode <= t_mode'(i_mode);
            r_key  <= i_value;
        end
    end

    // entry memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_wr) begin
            r_mem[r_fill[AW-1:0]] <= r_key;
        end
        r_rd_data <= r_mem[r_idx];
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.push_wr) begin
            r_fill <= r_fill + 1'b1;
        end else if (i_cmd.fill_dec) begin
            r_fill <= r_fill - 1'b1;
        end
    end

    // read index walks from the top entry down
    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_top) begin
            r_idx <= AW'(r_fill - 1'b1);
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    // search position: depth minus entry index, low bits kept
    assign pos_full = 32'(DEPTH) - 32'(r_idx);

    // output register
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status <= i_cmd.out_entry ? ST_OK : i_cmd.reply_st;
            r_data   <= i_cmd.out_entry ? r_rd_data : '0;
            r_pos    <= i_cmd.reply_hit ? pos_full[POS_W-1:0] : '0;
            r_last   <= i_cmd.out_last;
        end
    end

    // status towards the controller
    always_comb begin
        o_stat.mode     = r_mode;
        o_stat.empty    = (r_fill == '0);
        o_stat.full     = (r_fill == CW'(DEPTH));
        o_stat.idx_zero = (r_idx == '0);
        o_stat.match    = (r_rd_data == r_key);
        o_stat.out_free = out_free;
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_status;
    assign o_data     = r_data;
    assign o_position = r_pos;
    assign o_last     = r_last;

    // checks
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("output beat overwritten while stalled");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_wr |-> (r_fill != CW'(DEPTH)))
        else $error("push into a full stack");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_dec |-> (r_fill != '0) && (r_idx == AW'(r_fill - 1'b1)))
        else $error("pop without a top entry selected");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_wr |=> r_fill == CW'($past(r_fill) + 1'b1))
        else $error("fill count did not advance on push");

endmodule

[design/bounded_stack_with_search.sv]
// top level of the bounded stack with search
// depends on bsws_pkg, bsws_ctrl and bsws_dpath
//
// A DEPTH-entry last-in-first-out stack of signed 32-bit words.
// Input channel: i_valid / o_stall with i_mode and i_value; a beat is taken
// when i_valid is high and o_stall low. Output channel: o_valid / i_stall
// with o_status, o_data, o_position and o_last.
// Modes: push, pop, display (one beat per entry, top first, o_last on the
// bottom entry) and search (one beat, position = DEPTH minus entry index).
// One item is worked at a time; o_stall is high from acceptance until its
// last result has been loaded into the output register.
// Each entry walked passes through a fetch state and then an emit or check
// state, as the entry memory has a registered read port.
// Reset empties the stack and drops any pending output beat; memory
// contents are not cleared. While i_stall is high the output beat holds and
// the walk pauses before loading the next beat.
module bounded_stack_with_search #(
    parameter int DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [1:0]                            i_mode,
    input  logic signed [bsws_pkg::DATA_W-1:0]    i_value,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [1:0]                            o_status,
    output logic signed [bsws_pkg::DATA_W-1:0]    o_data,
    output logic [bsws_pkg::POS_W-1:0]            o_position,
    output logic                                  o_last
);
    import bsws_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    bsws_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    // storage and result path
    bsws_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_mode     (i_mode),
        .i_value    (i_value),
        .i_stall    (i_stall),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_data     (o_data),
        .o_position (o_position),
        .o_last     (o_last)
    );

endmodule

[test/bounded_stack_with_search_tb.sv]
// self-checking testbench for the bounded stack with search
// depends on bsws_pkg and bounded_stack_with_search; drives random and directed beats
module bounded_stack_with_search_tb;
    import bsws_pkg::*;

    localparam int STACK_DEPTH   = 8;
    localparam int RANDOM_ITEMS  = 410;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 4 * STACK_DEPTH + 16;

    // one reply beat as the block should produce it
    typedef struct packed {
        t_status            status;
        logic [DATA_W-1:0]  data;
        logic [POS_W-1:0]   position;
        logic               last;
    } t_reply;

    // one operation waiting to be sent, with the idle gap before it
    typedef struct {
        t_mode              mode;
        logic [DATA_W-1:0]  value;
        int                 gap;
        bit                 drain;
    } t_op;

    logic                       i_clk   = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic [1:0]                 i_mode  = 2'd0;
    logic signed [DATA_W-1:0]   i_value = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [1:0]                 o_status;
    logic signed [DATA_W-1:0]   o_data;
    logic [POS_W-1:0]           o_position;
    logic                       o_last;

    t_op            pending_ops[$];
    t_reply         expected_replies[$];
    logic [DATA_W-1:0] stk_word[STACK_DEPTH];
    int             stk_fill     = 0;
    int             mismatches   = 0;
    int             ops_sent     = 0;
    int             beats_seen   = 0;
    int             op_count[4]  = '{0, 0, 0, 0};
    int             status_count[4] = '{0, 0, 0, 0};
    int             gap_done     = 0;
    int             stall_left   = 0;
    int             calm_left    = 0;
    int             idle_cycles  = 0;

    bounded_stack_with_search #(
        .DEPTH(STACK_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_mode     (i_mode),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_data     (o_data),
        .o_position (o_position),
        .o_last     (o_last)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_reply make_reply(t_status st, logic [DATA_W-1:0] d,
                                          logic [POS_W-1:0] p, logic l);
        t_reply r;
        r.status   = st;
        r.data     = d;
        r.position = p;
        r.last     = l;
        return r;
    endfunction

    // stack behaviour: update the copy of the stack and queue the replies due
    task automatic stack_step(input t_mode m, input logic [DATA_W-1:0] v);
        int k;
        bit hit;
        logic [POS_W-1:0] pos;
        hit = 1'b0;
        case (m)
            MODE_PUSH: begin
                if (stk_fill >= STACK_DEPTH) begin
                    expected_replies.push_back(make_reply(ST_FULL, '0, '0, 1'b1));
                end else begin
                    stk_word[stk_fill] = v;
                    stk_fill++;
                    expected_replies.push_back(make_reply(ST_OK, '0, '0, 1'b1));
                end
            end
            MODE_POP: begin
                if (stk_fill == 0) begin
                    expected_replies.push_back(make_reply(ST_EMPTY, '0, '0, 1'b1));
                end else begin
                    stk_fill--;
                    expected_replies.push_back(
                        make_reply(ST_OK, stk_word[stk_fill], '0, 1'b1));
                end
            end
            MODE_SHOW: begin
                if (stk_fill == 0) begin
                    expected_replies.push_back(make_reply(ST_EMPTY, '0, '0, 1'b1));
                end else begin
                    for (k = stk_fill - 1; k >= 0; k--) begin
                        expected_replies.push_back(
                            make_reply(ST_OK, stk_word[k], '0, k == 0));
                    end
                end
            end
            default: begin
                if (stk_fill == 0) begin
                    expected_replies.push_back(make_reply(ST_EMPTY, '0, '0, 1'b1));
                end else begin
                    // first match from the top wins
                    for (k = stk_fill - 1; k >= 0 && !hit; k--) begin
                        if (stk_word[k] == v) begin
                            hit = 1'b1;
                            pos = POS_W'(STACK_DEPTH - k);
                            expected_replies.push_back(make_reply(ST_OK, '0, pos, 1'b1));
                        end
                    end
                    if (!hit) begin
                        expected_replies.push_back(
                            make_reply(ST_NOTFOUND, '0, '0, 1'b1));
                    end
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("beat %0d %s got %0h want %0h",
                                      beats_seen, name, got, want));
        end
    endtask

    task automatic queue_op(input t_mode m, input logic [DATA_W-1:0] v,
                            input int gap, input bit drain);
        t_op op;
        op.mode  = m;
        op.value = v;
        op.gap   = gap;
        op.drain = drain;
        pending_ops.push_back(op);
    endtask

    // driver: holds a stalled beat, else waits out the gap and sends the next op
    always @(posedge i_clk) begin
        t_op op;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                stack_step(t_mode'(i_mode), i_value);
                op_count[i_mode]++;
                ops_sent++;
            end
            if (pending_ops.size() == 0) begin
                i_valid <= 1'b0;
            end else if (pending_ops[0].drain && expected_replies.size() != 0) begin
                i_valid <= 1'b0;
            end else if (gap_done < pending_ops[0].gap) begin
                gap_done++;
                i_valid <= 1'b0;
            end else begin
                op = pending_ops.pop_front();
                gap_done = 0;
                i_valid <= 1'b1;
                i_mode  <= op.mode;
                i_value <= op.value;
            end
        end
    end

    // monitor: checks each reply beat and draws the stall for the next one
    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat status %0d data %0h",
                                              o_status, o_data));
                end else begin
                    want = expected_replies.pop_front();
                    check_field("status", DATA_W'(o_status), DATA_W'(want.status));
                    check_field("data", o_data, want.data);
                    check_field("position", DATA_W'(o_position),
                                DATA_W'(want.position));
                    check_field("last", DATA_W'(o_last), DATA_W'(want.last));
                end
                if (!$isunknown(o_status)) begin
                    status_count[o_status]++;
                end
                beats_seen++;
                if (calm_left > 0) begin
                    calm_left--;
                    stall_left = 0;
                end else if ($urandom_range(0, 7) == 0) begin
                    calm_left  = 24;
                    stall_left = 0;
                end else begin
                    stall_left = $urandom_range(0, 7);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no beat moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [DATA_W-1:0] word_pool[8];
        int n;
        int roll;
        int phase;
        int push_pct;
        int pop_pct;
        t_mode m;
        logic [DATA_W-1:0] v;

        word_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                      32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_3039};
        phase = 0;

        // directed: pop, display and search on an empty stack
        queue_op(MODE_POP,  32'h1234_5678, 0, 1'b0);
        queue_op(MODE_SHOW, 32'h0000_0000, 1, 1'b0);
        queue_op(MODE_FIND, 32'hffff_ffff, 0, 1'b0);
        // fill to the top with extreme words and a duplicate
        queue_op(MODE_PUSH, 32'h8000_0000, 0, 1'b0);
        queue_op(MODE_PUSH, 32'h7fff_ffff, 0, 1'b0);
        queue_op(MODE_PUSH, 32'h0000_0000, 2, 1'b0);
        queue_op(MODE_PUSH, 32'hffff_ffff, 0, 1'b0);
        queue_op(MODE_PUSH, 32'h5555_5555, 0, 1'b0);
        queue_op(MODE_PUSH, 32'haaaa_aaaa, 3, 1'b0);
        queue_op(MODE_PUSH, 32'hffff_ffff, 0, 1'b0);
        queue_op(MODE_PUSH, 32'h0000_3039, 0, 1'b0);
        // full stack: push refused, display all, searches at both ends
        queue_op(MODE_PUSH, 32'h0000_0001, 0, 1'b0);
        queue_op(MODE_SHOW, 32'hffff_ffff, 0, 1'b1);
        queue_op(MODE_FIND, 32'h8000_0000, 0, 1'b0);
        queue_op(MODE_FIND, 32'h0000_3039, 0, 1'b0);
        queue_op(MODE_FIND, 32'hffff_ffff, 0, 1'b0);
        queue_op(MODE_FIND, 32'h0000_002a, 0, 1'b0);
        // pop then look for the popped word, refill the slot
        queue_op(MODE_POP,  32'h0000_0000, 0, 1'b0);
        queue_op(MODE_FIND, 32'h0000_3039, 0, 1'b0);
        queue_op(MODE_PUSH, 32'h8000_0001, 0, 1'b0);
        queue_op(MODE_POP,  32'hffff_ffff, 0, 1'b0);
        queue_op(MODE_SHOW, 32'h0000_0000, 0, 1'b0);

        // random: phases that lean towards filling, draining or bursts
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 30 == 0) begin
                phase = $urandom_range(0, 3);
            end
            case (phase)
                0: begin
                    push_pct = 60;
                    pop_pct  = 70;
                end
                1: begin
                    push_pct = 20;
                    pop_pct  = 65;
                end
                default: begin
                    push_pct = 40;
                    pop_pct  = 65;
                end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < push_pct) begin
                m = MODE_PUSH;
            end else if (roll < pop_pct) begin
                m = MODE_POP;
            end else if (roll < 80) begin
                m = MODE_SHOW;
            end else begin
                m = MODE_FIND;
            end
            // a small word pool makes search hits and duplicates common
            if ((m == MODE_PUSH || m == MODE_FIND) && $urandom_range(0, 9) < 7) begin
                v = word_pool[$urandom_range(0, 7)];
            end else begin
                v = $urandom;
            end
            queue_op(m, v, (phase == 3) ? 0 : $urandom_range(0, 7), n % 97 == 96);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (expected_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (expected_replies.size() != 0) begin
            report_mismatch($sformatf("%0d replies never arrived",
                                      expected_replies.size()));
        end
        $display("ran %0d ops: %0d push, %0d pop, %0d display, %0d search",
                 ops_sent, op_count[MODE_PUSH], op_count[MODE_POP],
                 op_count[MODE_SHOW], op_count[MODE_FIND]);
        $display("checked %0d reply beats: %0d ok, %0d full, %0d empty, %0d not found",
                 beats_seen, status_count[ST_OK], status_count[ST_FULL],
                 status_count[ST_EMPTY], status_count[ST_NOTFOUND]);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
design/bsws_pkg.sv
design/bsws_ctrl.sv
design/bsws_dpath.sv
design/bounded_stack_with_search.sv
test/bounded_stack_with_search_tb.sv
